### src/detection_box_decode_filter_core_defines.svh
// =============================================================================
// Assertion macros for the detection box decode filter
// Concurrent assertion wrappers that compile away in synthesis builds.
// =============================================================================
`ifndef DETECTION_BOX_DECODE_FILTER_CORE_DEFINES_SVH
`define DETECTION_BOX_DECODE_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DBDF_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBDF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

// The condition must never be true.
`define DBDF_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error(msg);

`else

`define DBDF_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`define DBDF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`define DBDF_ASSERT_NEVER(lbl, ck, rn, cond, msg)

`endif

`endif

### src/dbdf_pkg.sv
// =============================================================================
// Detection box decode filter package
// Shared widths, reset values, register indexes and the queued job record.
// =============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dbdf_pkg;

    // Default sizing of the block.
    localparam int DBDF_MAX_CLASSES     = 128;
    localparam int DBDF_COORD_FRAC_BITS = 4;
    localparam int DBDF_QUEUE_DEPTH     = 4;

    // Field widths.
    localparam int SCORE_W     = 16;
    localparam int COORD_W     = 16;
    localparam int CLASS_W     = 8;
    localparam int FRAME_W     = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Register reset values.
    localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 16'd16384;
    localparam logic [FRAME_W-1:0] FRAME_RESET     = 13'd640;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SCORE_THRESHOLD = 2'd0,
        CFG_FRAME_WIDTH     = 2'd1,
        CFG_FRAME_HEIGHT    = 2'd2
    } cfg_index_t;

    // One decoded anchor handed from the front end to the box unit.
    typedef struct packed {
        logic [CLASS_W-1:0]        class_id;
        logic [SCORE_W-1:0]        confidence;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] box_width;
        logic signed [COORD_W-1:0] box_height;
    } dbdf_job_t;

endpackage

`default_nettype wire

### src/dbdf_front.sv
// =============================================================================
// Detection box decode filter front end
// Accepts class scores, tracks the best class per anchor and queues anchors.
// =============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "detection_box_decode_filter_core_defines.svh"

module dbdf_front #(
    parameter int MAX_CLASSES = dbdf_pkg::DBDF_MAX_CLASSES
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [dbdf_pkg::SCORE_W-1:0]        class_score,
    input  wire logic                                last_class,
    input  wire logic signed [dbdf_pkg::COORD_W-1:0] center_x,
    input  wire logic signed [dbdf_pkg::COORD_W-1:0] center_y,
    input  wire logic signed [dbdf_pkg::COORD_W-1:0] box_width,
    input  wire logic signed [dbdf_pkg::COORD_W-1:0] box_height,
    input  wire logic [dbdf_pkg::SCORE_W-1:0]        anchor_threshold,
    input  wire logic                                queue_full,
    output logic                                     push,
    output dbdf_pkg::dbdf_job_t                      job
);
    import dbdf_pkg::*;

    localparam int CNT_W = $clog2(MAX_CLASSES + 1);

    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [CLASS_W-1:0] best_class_reg, best_class_next;
    logic               found_reg, found_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               accept;
    logic               first;
    logic               counting;
    logic               better;
    logic [SCORE_W-1:0] base_score;
    logic [CLASS_W-1:0] base_class;
    logic               base_found;

    // A transaction is taken whenever the queue has room.
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // The first score of an anchor starts from the threshold.
    assign first      = (count_reg == '0);
    assign base_score = first ? anchor_threshold : best_score_reg;
    assign base_class = first ? '0 : best_class_reg;
    assign base_found = first ? 1'b0 : found_reg;

    // Scores beyond the class limit are ignored; ties keep the earlier class.
    assign counting = (count_reg < CNT_W'(MAX_CLASSES));
    assign better   = counting && (class_score > base_score);

    always_comb
    begin
        best_score_next = better ? class_score : base_score;
        best_class_next = better ? CLASS_W'(count_reg) : base_class;
        found_next      = better || base_found;
        if (last_class)
        begin
            count_next = '0;
        end
        else if (counting)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Running best for the anchor in progress.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= '0;
            best_class_reg <= '0;
            found_reg      <= 1'b0;
            count_reg      <= '0;
        end
        else if (accept)
        begin
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            found_reg      <= found_next;
            count_reg      <= count_next;
        end
    end

    // Only anchors with a passing class go on to the box unit.
    assign push = accept && last_class && found_next;

    always_comb
    begin
        job.class_id   = best_class_next;
        job.confidence = best_score_next;
        job.center_x   = center_x;
        job.center_y   = center_y;
        job.box_width  = box_width;
        job.box_height = box_height;
    end

    `DBDF_ASSERT_NEXT(a_front_last_restarts, clk, rst_n, accept && last_class, count_reg == '0, "anchor count not cleared after last class")
    `DBDF_ASSERT_IMPLY(a_front_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_CLASSES), "class count beyond limit")
    `DBDF_ASSERT_NEXT(a_front_count_step, clk, rst_n, accept && !last_class && counting, count_reg == $past(count_reg) + CNT_W'(1), "class count did not advance")

endmodule

`default_nettype wire

### src/dbdf_queue.sv
// =============================================================================
// Detection box decode filter queue
// Short first-in first-out buffer between the front end and the box unit.
// =============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "detection_box_decode_filter_core_defines.svh"

module dbdf_queue #(
    parameter int DEPTH = dbdf_pkg::DBDF_QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire dbdf_pkg::dbdf_job_t  push_data,
    output logic                      full,
    input  wire logic                 pop,
    output dbdf_pkg::dbdf_job_t       pop_data,
    output logic                      not_empty
);
    import dbdf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dbdf_job_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `DBDF_ASSERT_NEVER(a_queue_overflow, clk, rst_n, push && full, "push into full queue")
    `DBDF_ASSERT_NEVER(a_queue_underflow, clk, rst_n, pop && !not_empty, "pop from empty queue")
    `DBDF_ASSERT_NEXT(a_queue_fill, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CNT_W'(1), "queue count did not grow")

endmodule

`default_nettype wire

### src/dbdf_back.sv
// =============================================================================
// Detection box decode filter box unit
// Turns queued anchors into clamped corners, then into the output detection.
// =============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "detection_box_decode_filter_core_defines.svh"

module dbdf_back #(
    parameter int COORD_FRAC_BITS = dbdf_pkg::DBDF_COORD_FRAC_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_valid,
    input  wire dbdf_pkg::dbdf_job_t           job,
    output logic                               job_pop,
    input  wire logic [dbdf_pkg::FRAME_W-1:0]  frame_width,
    input  wire logic [dbdf_pkg::FRAME_W-1:0]  frame_height,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [dbdf_pkg::CLASS_W-1:0]       class_id,
    output logic [dbdf_pkg::SCORE_W-1:0]       confidence,
    output logic [dbdf_pkg::COORD_W-1:0]       left,
    output logic [dbdf_pkg::COORD_W-1:0]       top,
    output logic [dbdf_pkg::COORD_W-1:0]       width_out,
    output logic [dbdf_pkg::COORD_W-1:0]       height_out
);
    import dbdf_pkg::*;

    // Clamp a signed corner into 0..hi.
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [COORD_W:0] v,
        input logic [COORD_W-1:0]      hi
    );
        logic [COORD_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v[COORD_W-1:0] > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // Largest corner for a frame size; a zero size acts as one pixel.
    function automatic logic [COORD_W-1:0] corner_bound(
        input logic [FRAME_W-1:0] frame
    );
        logic [FRAME_W-1:0] f1;
        logic [31:0]        m;
        f1 = (frame == '0) ? '0 : frame - FRAME_W'(1);
        m  = 32'(f1) << COORD_FRAC_BITS;
        return (m > 32'd65535) ? {COORD_W{1'b1}} : m[COORD_W-1:0];
    endfunction

    logic [COORD_W-1:0] x_bound_reg, y_bound_reg;

    logic               s1_valid_reg, s1_valid_next;
    logic [CLASS_W-1:0] s1_class_reg;
    logic [SCORE_W-1:0] s1_conf_reg;
    logic [COORD_W-1:0] s1_x1_reg, s1_y1_reg, s1_x2_reg, s1_y2_reg;

    logic               out_valid_reg, out_valid_next;
    logic [CLASS_W-1:0] out_class_reg;
    logic [SCORE_W-1:0] out_conf_reg;
    logic [COORD_W-1:0] out_left_reg, out_top_reg, out_w_reg, out_h_reg;

    logic signed [COORD_W-1:0] half_w, half_h;
    logic signed [COORD_W:0]   x1_raw, y1_raw, x2_raw, y2_raw;
    logic                      s1_nonzero;
    logic                      s1_leave;
    logic                      s1_load;
    logic                      out_load;
    logic                      out_take;

    // Frame bounds are registered from the configuration registers and follow them in the next cycle.
    always_ff @(posedge clk)
    begin
        x_bound_reg <= corner_bound(frame_width);
        y_bound_reg <= corner_bound(frame_height);
    end

    // Corners from centre and floor-halved size, at one extra bit.
    always_comb
    begin
        half_w = job.box_width >>> 1;
        half_h = job.box_height >>> 1;
        x1_raw = {job.center_x[COORD_W-1], job.center_x} - {half_w[COORD_W-1], half_w};
        y1_raw = {job.center_y[COORD_W-1], job.center_y} - {half_h[COORD_W-1], half_h};
        x2_raw = {job.center_x[COORD_W-1], job.center_x} + {half_w[COORD_W-1], half_w};
        y2_raw = {job.center_y[COORD_W-1], job.center_y} + {half_h[COORD_W-1], half_h};
    end

    // Handshake between the corner stage and the output register.
    assign s1_nonzero = (s1_x2_reg > s1_x1_reg) && (s1_y2_reg > s1_y1_reg);
    assign out_load   = !out_valid_reg || !out_stall;
    assign out_take   = s1_valid_reg && s1_nonzero && out_load;
    assign s1_leave   = s1_valid_reg && (!s1_nonzero || out_load);
    assign s1_load    = !s1_valid_reg || s1_leave;
    assign job_pop    = job_valid && s1_load;

    always_comb
    begin
        if (job_pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_leave)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (out_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Corner stage payload.
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            s1_class_reg <= job.class_id;
            s1_conf_reg  <= job.confidence;
            s1_x1_reg    <= clamp_coord(x1_raw, x_bound_reg);
            s1_y1_reg    <= clamp_coord(y1_raw, y_bound_reg);
            s1_x2_reg    <= clamp_coord(x2_raw, x_bound_reg);
            s1_y2_reg    <= clamp_coord(y2_raw, y_bound_reg);
        end
    end

    // Output register payload; boxes of zero size are dropped above.
    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_class_reg <= s1_class_reg;
            out_conf_reg  <= s1_conf_reg;
            out_left_reg  <= s1_x1_reg;
            out_top_reg   <= s1_y1_reg;
            out_w_reg     <= s1_x2_reg - s1_x1_reg;
            out_h_reg     <= s1_y2_reg - s1_y1_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign class_id   = out_class_reg;
    assign confidence = out_conf_reg;
    assign left       = out_left_reg;
    assign top        = out_top_reg;
    assign width_out  = out_w_reg;
    assign height_out = out_h_reg;

    `DBDF_ASSERT_IMPLY(a_back_size_nonzero, clk, rst_n, out_valid_reg, (out_w_reg != '0) && (out_h_reg != '0), "emitted box of zero size")
    `DBDF_ASSERT_IMPLY(a_back_corner_bound, clk, rst_n, s1_valid_reg, (s1_x2_reg <= x_bound_reg) && (s1_y2_reg <= y_bound_reg), "corner beyond frame")
    `DBDF_ASSERT_NEXT(a_back_pop_fills, clk, rst_n, job_pop, s1_valid_reg, "popped job lost")

endmodule

`default_nettype wire

### src/detection_box_decode_filter_core.sv
// =============================================================================
// Detection box decode filter core
// Picks the best class of each anchor and emits its clamped detection box.
// =============================================================================
// The block takes one class score per cycle while in_stall is low. Each
// anchor is a run of scores ending with the transaction marked last_class,
// which also carries the box centre and size. The front end keeps the running
// best class and passes each anchor that has a class above the threshold into
// a short queue; the box unit registers the clamped corners in its corner
// stage and the size in its output register. Input stalls only while the queue
// is full, which happens only when the output side holds off for longer than
// the queue depth allows. Configuration writes are always taken and should be
// made while no anchor is in flight.
`timescale 1ns / 1ps
`default_nettype none

module detection_box_decode_filter_core #(
    parameter int MAX_CLASSES     = dbdf_pkg::DBDF_MAX_CLASSES,
    parameter int COORD_FRAC_BITS = dbdf_pkg::DBDF_COORD_FRAC_BITS,
    parameter int QUEUE_DEPTH     = dbdf_pkg::DBDF_QUEUE_DEPTH
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [dbdf_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [dbdf_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [dbdf_pkg::SCORE_W-1:0]           class_score,
    input  wire logic                                   last_class,
    input  wire logic signed [dbdf_pkg::COORD_W-1:0]    center_x,
    input  wire logic signed [dbdf_pkg::COORD_W-1:0]    center_y,
    input  wire logic signed [dbdf_pkg::COORD_W-1:0]    box_width,
    input  wire logic signed [dbdf_pkg::COORD_W-1:0]    box_height,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [dbdf_pkg::CLASS_W-1:0]                class_id,
    output logic [dbdf_pkg::SCORE_W-1:0]                confidence,
    output logic [dbdf_pkg::COORD_W-1:0]                left,
    output logic [dbdf_pkg::COORD_W-1:0]                top,
    output logic [dbdf_pkg::COORD_W-1:0]                width_out,
    output logic [dbdf_pkg::COORD_W-1:0]                height_out
);
    import dbdf_pkg::*;

    logic [SCORE_W-1:0] threshold_reg;
    logic [FRAME_W-1:0] frame_width_reg;
    logic [FRAME_W-1:0] frame_height_reg;

    logic      queue_full;
    logic      queue_push;
    logic      queue_pop;
    logic      queue_not_empty;
    dbdf_job_t front_job;
    dbdf_job_t back_job;

    // Configuration registers; writes are always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RESET;
            frame_width_reg  <= FRAME_RESET;
            frame_height_reg <= FRAME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SCORE_THRESHOLD: threshold_reg    <= cfg_data[SCORE_W-1:0];
                CFG_FRAME_WIDTH:     frame_width_reg  <= cfg_data[FRAME_W-1:0];
                CFG_FRAME_HEIGHT:    frame_height_reg <= cfg_data[FRAME_W-1:0];
                default:             ;
            endcase
        end
    end

    // Score tracking per anchor.
    dbdf_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .class_score      (class_score),
        .last_class       (last_class),
        .center_x         (center_x),
        .center_y         (center_y),
        .box_width        (box_width),
        .box_height       (box_height),
        .anchor_threshold (threshold_reg),
        .queue_full       (queue_full),
        .push             (queue_push),
        .job              (front_job)
    );

    // Decoupling queue.
    dbdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_data (front_job),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (back_job),
        .not_empty (queue_not_empty)
    );

    // Box decode and clamp.
    dbdf_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (queue_not_empty),
        .job          (back_job),
        .job_pop      (queue_pop),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .class_id     (class_id),
        .confidence   (confidence),
        .left         (left),
        .top          (top),
        .width_out    (width_out),
        .height_out   (height_out)
    );

endmodule

`default_nettype wire
